FILE: sv/skts_pkg.sv
// Shared types and constants for the sorted key table search unit.
// No dependencies; imported by every module of the block but the generic skts_ram.
package skts_pkg;

   // Table size and derived widths
   localparam int DEPTH   = 512;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;

   // Fixed field widths of the item ports
   localparam int CMD_W   = 3;
   localparam int KEY_W   = 30;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int IDX_W   = 9;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 9;
   localparam int ECNT_W  = 10;

   // Width for comparing the read index against the fill count
   localparam int CMP_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_SORT   = 3'd2,
      CMD_SEARCH = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SORT_CHK,
      S_SORT_LOAD,
      S_SORT_CMP,
      S_SORT_END,
      S_SRCH_CHK,
      S_SRCH_CMP,
      S_READ_WAIT,
      S_RESULT
   } state_type;

   // Datapath operations issued by the controller, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_TAKE,
      OP_CLEAR,
      OP_APPEND,
      OP_FULL,
      OP_SORT_START,
      OP_SORT_RD0,
      OP_SORT_LOAD,
      OP_SORT_CMP,
      OP_SORT_END,
      OP_SRCH_START,
      OP_SRCH_RD,
      OP_SRCH_STEP,
      OP_READ_RD,
      OP_RES_OK,
      OP_RES_NOT_FOUND,
      OP_RES_RANGE,
      OP_RES_REC
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type req_cmd;
      logic    full;
      logic    idx_ok;
      logic    sort_go;
      logic    last_cmp;
      logic    srch_go;
      logic    hit;
      logic    out_free;
   } dp_stat_type;

endpackage

FILE: sv/skts_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module skts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/skts_ctrl.sv
// Controller state machine: sequences clear, append, sort, search and read.
// Depends on skts_pkg; drives skts_dpath through ctrl_cmd_type.
module skts_ctrl
   import skts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (stat.req_cmd)
               CMD_SORT:   state_in = S_SORT_CHK;
               CMD_SEARCH: state_in = S_SRCH_CHK;
               CMD_READ:   state_in = stat.idx_ok ? S_READ_WAIT : S_RESULT;
               default:    state_in = S_RESULT;
            endcase
         end
         S_SORT_CHK: begin
            state_in = stat.sort_go ? S_SORT_LOAD : S_RESULT;
         end
         S_SORT_LOAD: state_in = S_SORT_CMP;
         S_SORT_CMP: begin
            if (stat.last_cmp) state_in = S_SORT_END;
         end
         S_SORT_END: state_in = S_SORT_CHK;
         S_SRCH_CHK: begin
            state_in = stat.srch_go ? S_SRCH_CMP : S_RESULT;
         end
         S_SRCH_CMP: begin
            state_in = stat.hit ? S_RESULT : S_SRCH_CHK;
         end
         S_READ_WAIT: state_in = S_RESULT;
         S_RESULT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs: one datapath operation per state
   always_comb begin
      ctrl.op       = OP_NONE;
      ctrl.load_out = 1'b0;
      req_ready     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) ctrl.op = OP_TAKE;
         end
         S_DISPATCH: begin
            case (stat.req_cmd)
               CMD_CLEAR:  ctrl.op = OP_CLEAR;
               CMD_APPEND: ctrl.op = stat.full ? OP_FULL : OP_APPEND;
               CMD_SORT:   ctrl.op = OP_SORT_START;
               CMD_SEARCH: ctrl.op = OP_SRCH_START;
               CMD_READ:   ctrl.op = stat.idx_ok ? OP_READ_RD : OP_RES_RANGE;
               default:    ctrl.op = OP_RES_OK;
            endcase
         end
         S_SORT_CHK:  ctrl.op = stat.sort_go ? OP_SORT_RD0 : OP_RES_OK;
         S_SORT_LOAD: ctrl.op = OP_SORT_LOAD;
         S_SORT_CMP:  ctrl.op = OP_SORT_CMP;
         S_SORT_END:  ctrl.op = OP_SORT_END;
         S_SRCH_CHK:  ctrl.op = stat.srch_go ? OP_SRCH_RD : OP_RES_NOT_FOUND;
         S_SRCH_CMP:  ctrl.op = stat.hit ? OP_RES_REC : OP_SRCH_STEP;
         S_READ_WAIT: ctrl.op = OP_RES_REC;
         S_RESULT:    ctrl.load_out = stat.out_free;
         default:     ctrl.op = OP_NONE;
      endcase
   end

endmodule

FILE: sv/skts_dpath.sv
// Datapath: held item, fill count, sort and search registers, record RAM
// and output register. Depends on skts_pkg and skts_ram.
module skts_dpath
   import skts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        ctrl,
   output dp_stat_type         stat,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_key_in,
   input  logic [YEAR_W-1:0]   req_year_in,
   input  logic [MONTH_W-1:0]  req_month_in,
   input  logic [DAY_W-1:0]    req_day_in,
   input  logic [IDX_W-1:0]    req_index_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [POS_W-1:0]    rsp_position,
   output logic [KEY_W-1:0]    rsp_key_out,
   output logic [YEAR_W-1:0]   rsp_year_out,
   output logic [MONTH_W-1:0]  rsp_month_out,
   output logic [DAY_W-1:0]    rsp_day_out,
   output logic [ECNT_W-1:0]   rsp_entry_count
);

   // Control registers (reset)
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              out_valid_ff, out_valid_in;

   // Payload registers
   cmd_type           hold_cmd_ff, hold_cmd_in;
   rec_type           hold_rec_ff, hold_rec_in;
   logic [IDX_W-1:0]  hold_idx_ff, hold_idx_in;
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic              swapped_ff, swapped_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   rec_type           carry_ff, carry_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [ADDR_W-1:0] mid_ff, mid_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_pos_ff, res_pos_in;
   rec_type           res_rec_ff, res_rec_in;
   status_type        out_status_ff, out_status_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   rec_type           out_rec_ff, out_rec_in;
   logic [ECNT_W-1:0] out_cnt_ff, out_cnt_in;

   // RAM port signals
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   rec_type           mem_wdata, mem_rdata;
   logic [REC_W-1:0]  mem_rbits;

   logic [SUM_W-1:0]  mid_sum;
   logic [ADDR_W-1:0] mid_calc;
   logic [SUM_W-1:0]  cmp_end;

   skts_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rbits)
   );

   assign mem_rdata = rec_type'(mem_rbits);

   // Halving midpoint: lo + (hi - 1 - lo) / 2, valid while lo < hi
   assign mid_sum  = SUM_W'(lo_ff) + SUM_W'(hi_ff) - SUM_W'(1);
   assign mid_calc = ADDR_W'(mid_sum >> 1);

   // Position just past the current compare, against the pass limit
   assign cmp_end  = SUM_W'(j_ff) + SUM_W'(1) + SUM_W'(pass_ff);

   // Status back to the controller
   always_comb begin
      stat.req_cmd  = hold_cmd_ff;
      stat.full     = (count_ff == CNT_W'(DEPTH));
      stat.idx_ok   = (CMP_W'(hold_idx_ff) < CMP_W'(count_ff));
      stat.sort_go  = swapped_ff && (pass_ff < count_ff);
      stat.last_cmp = (cmp_end == SUM_W'(count_ff));
      stat.srch_go  = (lo_ff < hi_ff);
      stat.hit      = (mem_rdata.key == hold_rec_ff.key);
      stat.out_free = !out_valid_ff || rsp_ready;
   end

   // Operation decode
   always_comb begin
      count_in      = count_ff;
      hold_cmd_in   = hold_cmd_ff;
      hold_rec_in   = hold_rec_ff;
      hold_idx_in   = hold_idx_ff;
      pass_in       = pass_ff;
      swapped_in    = swapped_ff;
      j_in          = j_ff;
      carry_in      = carry_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_rec_in    = res_rec_ff;
      mem_we        = 1'b0;
      mem_waddr     = j_ff;
      mem_wdata     = carry_ff;
      mem_re        = 1'b0;
      mem_raddr     = mid_calc;
      case (ctrl.op)
         OP_TAKE: begin
            hold_cmd_in       = cmd_type'(req_cmd);
            hold_rec_in.key   = req_key_in;
            hold_rec_in.year  = req_year_in;
            hold_rec_in.month = req_month_in;
            hold_rec_in.day   = req_day_in;
            hold_idx_in       = req_index_in;
         end
         OP_CLEAR: begin
            count_in      = '0;
            res_status_in = ST_OK;
            res_pos_in    = '0;
            res_rec_in    = '0;
         end
         OP_APPEND: begin
            mem_we        = 1'b1;
            mem_waddr     = ADDR_W'(count_ff);
            mem_wdata     = hold_rec_ff;
            count_in      = count_ff + CNT_W'(1);
            res_status_in = ST_OK;
            res_pos_in    = '0;
            res_rec_in    = '0;
         end
         OP_FULL: begin
            res_status_in = ST_FULL;
            res_pos_in    = '0;
            res_rec_in    = '0;
         end
         OP_SORT_START: begin
            pass_in    = CNT_W'(1);
            swapped_in = 1'b1;
         end
         OP_SORT_RD0: begin
            mem_re     = 1'b1;
            mem_raddr  = '0;
            swapped_in = 1'b0;
         end
         OP_SORT_LOAD: begin
            carry_in  = mem_rdata;
            j_in      = '0;
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(1);
         end
         // Bubble step: the larger record travels on in the carry register
         OP_SORT_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            if (carry_ff.key > mem_rdata.key) begin
               mem_wdata  = mem_rdata;
               swapped_in = 1'b1;
            end else begin
               mem_wdata  = carry_ff;
               carry_in   = mem_rdata;
            end
            j_in      = j_ff + ADDR_W'(1);
            mem_re    = 1'b1;
            mem_raddr = j_ff + ADDR_W'(2);
         end
         OP_SORT_END: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = carry_ff;
            pass_in   = pass_ff + CNT_W'(1);
         end
         OP_SRCH_START: begin
            lo_in = '0;
            hi_in = count_ff;
         end
         OP_SRCH_RD: begin
            mid_in    = mid_calc;
            mem_re    = 1'b1;
            mem_raddr = mid_calc;
         end
         OP_SRCH_STEP: begin
            if (hold_rec_ff.key > mem_rdata.key) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
         end
         OP_READ_RD: begin
            mid_in    = ADDR_W'(hold_idx_ff);
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(hold_idx_ff);
         end
         OP_RES_OK: begin
            res_status_in = ST_OK;
            res_pos_in    = '0;
            res_rec_in    = '0;
         end
         OP_RES_NOT_FOUND: begin
            res_status_in = ST_NOT_FOUND;
            res_pos_in    = '0;
            res_rec_in    = '0;
         end
         OP_RES_RANGE: begin
            res_status_in = ST_RANGE;
            res_pos_in    = '0;
            res_rec_in    = '0;
         end
         OP_RES_REC: begin
            res_status_in = ST_OK;
            res_pos_in    = mid_ff;
            res_rec_in    = mem_rdata;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Output register
   always_comb begin
      out_status_in = out_status_ff;
      out_pos_in    = out_pos_ff;
      out_rec_in    = out_rec_ff;
      out_cnt_in    = out_cnt_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      if (ctrl.load_out) begin
         out_status_in = res_status_ff;
         out_pos_in    = POS_W'(res_pos_ff);
         out_rec_in    = res_rec_ff;
         out_cnt_in    = ECNT_W'(count_ff);
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff   <= hold_cmd_in;
      hold_rec_ff   <= hold_rec_in;
      hold_idx_ff   <= hold_idx_in;
      pass_ff       <= pass_in;
      swapped_ff    <= swapped_in;
      j_ff          <= j_in;
      carry_ff      <= carry_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_rec_ff    <= res_rec_in;
      out_status_ff <= out_status_in;
      out_pos_ff    <= out_pos_in;
      out_rec_ff    <= out_rec_in;
      out_cnt_ff    <= out_cnt_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_key_out     = out_rec_ff.key;
   assign rsp_year_out    = out_rec_ff.year;
   assign rsp_month_out   = out_rec_ff.month;
   assign rsp_day_out     = out_rec_ff.day;
   assign rsp_entry_count = out_cnt_ff;

endmodule

FILE: sv/sorted_key_table_search_unit.sv
// Sorted key table search unit: top level joining controller and datapath.
// Depends on skts_pkg, skts_ctrl, skts_dpath (and skts_ram below it).
//
// Usage: one command item enters on the req_ channel (valid/ready) and
// exactly one result item leaves on the rsp_ channel (valid/ready).
// Commands: clear, append, stable ascending sort, binary search by key,
// read at index. Items are worked on one at a time; req_ready is high
// while the controller is idle, from the cycle after a result is loaded.
// Steps from acceptance to result valid (receiver ready):
//   clear, append, unknown command and out-of-range read: dispatch, result
//   read: dispatch, RAM read, result
//   search: dispatch, per probe a RAM read and a key compare, then result
//   sort: dispatch, then per pass a first read, a load, the compares and
//         an end step; passes stop early once a pass makes no swap.
// The record RAM allows one read and one write per cycle, with its read
// data registered.
// A finished result waits in the output register; the next item is
// accepted meanwhile and its result waits until the register is free.
// Reset empties the table (fill count zero) and drops any pending
// result; the record RAM itself is not cleared.
module sorted_key_table_search_unit
   import skts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_key_in,
   input  logic [YEAR_W-1:0]   req_year_in,
   input  logic [MONTH_W-1:0]  req_month_in,
   input  logic [DAY_W-1:0]    req_day_in,
   input  logic [IDX_W-1:0]    req_index_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [POS_W-1:0]    rsp_position,
   output logic [KEY_W-1:0]    rsp_key_out,
   output logic [YEAR_W-1:0]   rsp_year_out,
   output logic [MONTH_W-1:0]  rsp_month_out,
   output logic [DAY_W-1:0]    rsp_day_out,
   output logic [ECNT_W-1:0]   rsp_entry_count
);

   ctrl_cmd_type ctrl;
   dp_stat_type  stat;

   skts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   skts_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_key_in      (req_key_in),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_index_in    (req_index_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_key_out     (rsp_key_out),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

FILE: sv/skts_chk.sv
// Port-level checker for the sorted key table search unit, with its bind.
// Depends on skts_pkg and the top level's port list.
module skts_chk
   import skts_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STAT_W-1:0]   rsp_status,
   input logic [POS_W-1:0]    rsp_position,
   input logic [KEY_W-1:0]    rsp_key_out,
   input logic [YEAR_W-1:0]   rsp_year_out,
   input logic [MONTH_W-1:0]  rsp_month_out,
   input logic [DAY_W-1:0]    rsp_day_out,
   input logic [ECNT_W-1:0]   rsp_entry_count
);

   // Reset drops any pending result item
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result item holds its status and count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count))
      else $error("stalled result changed");

   // Any failure status carries zero record fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_position == '0)
         && (rsp_key_out == '0) && (rsp_year_out == '0)
         && (rsp_month_out == '0) && (rsp_day_out == '0))
      else $error("failure result with record fields");

   // A dropped append means the table is exactly full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (int'(rsp_entry_count) == DEPTH))
      else $error("full status with table not full");

   // Fill count never exceeds the table size
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_entry_count) <= DEPTH))
      else $error("entry count beyond table size");

endmodule

bind sorted_key_table_search_unit skts_chk u_skts_chk (.*);

FILE: tb/sv/skts_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted key table search unit: keeps a shadow copy of
// the record table, predicts one result per accepted command and compares.
// Depends on skts_pkg for widths, command and status codes.
module skts_result_checker
   import skts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_key_in,
   input  logic [YEAR_W-1:0]   req_year_in,
   input  logic [MONTH_W-1:0]  req_month_in,
   input  logic [DAY_W-1:0]    req_day_in,
   input  logic [IDX_W-1:0]    req_index_in,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [STAT_W-1:0]   rsp_status,
   input  logic [POS_W-1:0]    rsp_position,
   input  logic [KEY_W-1:0]    rsp_key_out,
   input  logic [YEAR_W-1:0]   rsp_year_out,
   input  logic [MONTH_W-1:0]  rsp_month_out,
   input  logic [DAY_W-1:0]    rsp_day_out,
   input  logic [ECNT_W-1:0]   rsp_entry_count,
   output int                  fault_count,
   output int                  pending_results
);

   typedef struct packed {
      status_type          status;
      logic [POS_W-1:0]    position;
      logic [KEY_W-1:0]    key;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [ECNT_W-1:0]   entry_count;
   } outcome_type;

   rec_type      shadow_records [DEPTH];
   int           held_count;
   outcome_type  outcome_q [$];

   // Stable bubble sort by key, stopping after a pass without a swap
   function automatic void bubble_shadow();
      rec_type tmp;
      int      pass;
      bit      swapped;
      pass    = 1;
      swapped = 1'b1;
      while (swapped && pass < held_count) begin
         swapped = 1'b0;
         for (int j = 0; j + pass < held_count; j++) begin
            if (shadow_records[j].key > shadow_records[j + 1].key) begin
               tmp                   = shadow_records[j];
               shadow_records[j]     = shadow_records[j + 1];
               shadow_records[j + 1] = tmp;
               swapped               = 1'b1;
            end
         end
         pass++;
      end
   endfunction

   // Halving search over [lo, hi); -1 when the key is not met
   function automatic int find_key(logic [KEY_W-1:0] key);
      int lo, hi, mid;
      lo = 0;
      hi = held_count;
      while (lo < hi) begin
         mid = lo + (hi - 1 - lo) / 2;
         if (shadow_records[mid].key == key) return mid;
         if (key > shadow_records[mid].key) lo = mid + 1;
         else hi = mid;
      end
      return -1;
   endfunction

   function automatic outcome_type record_at(int pos);
      outcome_type res;
      res          = '0;
      res.status   = ST_OK;
      res.position = pos[POS_W-1:0];
      res.key      = shadow_records[pos].key;
      res.year     = shadow_records[pos].year;
      res.month    = shadow_records[pos].month;
      res.day      = shadow_records[pos].day;
      return res;
   endfunction

   // Apply one command to the shadow table and give its result
   function automatic outcome_type predict_outcome(logic [CMD_W-1:0]   cmd,
                                                   logic [KEY_W-1:0]   key,
                                                   logic [YEAR_W-1:0]  year,
                                                   logic [MONTH_W-1:0] month,
                                                   logic [DAY_W-1:0]   day,
                                                   logic [IDX_W-1:0]   index);
      outcome_type res;
      int          hit;
      res = '0;
      case (cmd)
         CMD_CLEAR: held_count = 0;
         CMD_APPEND: begin
            if (held_count < DEPTH) begin
               shadow_records[held_count] = {key, year, month, day};
               held_count++;
            end else begin
               res.status = ST_FULL;
            end
         end
         CMD_SORT: bubble_shadow();
         CMD_SEARCH: begin
            hit = find_key(key);
            if (hit >= 0) res = record_at(hit);
            else res.status = ST_NOT_FOUND;
         end
         CMD_READ: begin
            if (int'(index) < held_count) res = record_at(int'(index));
            else res.status = ST_RANGE;
         end
         default: ;   // spare codes leave the table alone
      endcase
      res.entry_count = held_count[ECNT_W-1:0];
      return res;
   endfunction

   // Compare results first, then log the command taken at the same edge
   always @(posedge clock) begin
      outcome_type seen, want;
      if (reset) begin
         held_count = 0;
         outcome_q.delete();
         fault_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.status      = status_type'(rsp_status);
            seen.position    = rsp_position;
            seen.key         = rsp_key_out;
            seen.year        = rsp_year_out;
            seen.month       = rsp_month_out;
            seen.day         = rsp_day_out;
            seen.entry_count = rsp_entry_count;
            if (outcome_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%t: unexpected result, status %0d count %0d, nothing pending",
                           $realtime, seen.status, seen.entry_count);
            end else begin
               want = outcome_q.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("%t: result mismatch", $realtime);
                     $display("   expected st %0d pos %0d key %0d y %0d m %0d d %0d cnt %0d",
                              want.status, want.position, want.key, want.year,
                              want.month, want.day, want.entry_count);
                     $display("   actual   st %0d pos %0d key %0d y %0d m %0d d %0d cnt %0d",
                              seen.status, seen.position, seen.key, seen.year,
                              seen.month, seen.day, seen.entry_count);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            outcome_q.push_back(predict_outcome(req_cmd, req_key_in, req_year_in,
                                                req_month_in, req_day_in, req_index_in));
      end
      pending_results = outcome_q.size();
   end

endmodule

FILE: tb/sv/tb_sorted_key_table_search_unit.sv
`timescale 1ns / 1ps
// Testbench top for the sorted key table search unit: clock, reset, command
// stimulus, result back-pressure and the verdict.
// Depends on skts_pkg, sorted_key_table_search_unit and skts_result_checker.
module tb_sorted_key_table_search_unit;
   import skts_pkg::*;

   localparam int ITEM_TARGET = 1650;
   localparam int HOLD_CYCLES = 300;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd         = '0;
   logic [KEY_W-1:0]    req_key_in      = '0;
   logic [YEAR_W-1:0]   req_year_in     = '0;
   logic [MONTH_W-1:0]  req_month_in    = '0;
   logic [DAY_W-1:0]    req_day_in      = '0;
   logic [IDX_W-1:0]    req_index_in    = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [POS_W-1:0]    rsp_position;
   logic [KEY_W-1:0]    rsp_key_out;
   logic [YEAR_W-1:0]   rsp_year_out;
   logic [MONTH_W-1:0]  rsp_month_out;
   logic [DAY_W-1:0]    rsp_day_out;
   logic [ECNT_W-1:0]   rsp_entry_count;

   int                  fault_count;
   int                  pending_results;

   // Stimulus bookkeeping: fill level and keys held since the last clear
   int                  items_sent      = 0;
   int                  fill_level      = 0;
   logic [KEY_W-1:0]    held_keys [$];
   bit                  no_gaps         = 1'b0;
   bit                  results_held_off = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_key_table_search_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key_in      (req_key_in),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_index_in    (req_index_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_key_out     (rsp_key_out),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_entry_count (rsp_entry_count)
   );

   skts_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key_in      (req_key_in),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_index_in    (req_index_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_key_out     (rsp_key_out),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_entry_count (rsp_entry_count),
      .fault_count     (fault_count),
      .pending_results (pending_results)
   );

   // Mostly no gap or a short one, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] rand_key(bit narrow);
      if (narrow) return KEY_W'($urandom_range(0, 31));
      return KEY_W'($urandom);
   endfunction

   // Offer one item from a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic [CMD_W-1:0]   cmd,
                            input logic [KEY_W-1:0]   key,
                            input logic [YEAR_W-1:0]  year,
                            input logic [MONTH_W-1:0] month,
                            input logic [DAY_W-1:0]   day,
                            input logic [IDX_W-1:0]   index);
      int gap;
      gap = no_gaps ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd      <= cmd;
      req_key_in   <= key;
      req_year_in  <= year;
      req_month_in <= month;
      req_day_in   <= day;
      req_index_in <= index;
      req_valid    <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      case (cmd)
         CMD_CLEAR: begin
            fill_level = 0;
            held_keys.delete();
         end
         CMD_APPEND: begin
            if (fill_level < DEPTH) begin
               fill_level++;
               held_keys.push_back(key);
            end
         end
         default: ;
      endcase
   endtask

   task automatic append_rec(input logic [KEY_W-1:0]   key,
                             input logic [YEAR_W-1:0]  year,
                             input logic [MONTH_W-1:0] month,
                             input logic [DAY_W-1:0]   day);
      send_item(CMD_APPEND, key, year, month, day, IDX_W'($urandom));
   endtask

   task automatic search_for(input logic [KEY_W-1:0] key);
      send_item(CMD_SEARCH, key, YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                IDX_W'($urandom));
   endtask

   task automatic read_at(input logic [IDX_W-1:0] index);
      send_item(CMD_READ, KEY_W'($urandom), YEAR_W'($urandom), MONTH_W'($urandom),
                DAY_W'($urandom), index);
   endtask

   task automatic plain(input logic [CMD_W-1:0] cmd);
      send_item(cmd, KEY_W'($urandom), YEAR_W'($urandom), MONTH_W'($urandom),
                DAY_W'($urandom), IDX_W'($urandom));
   endtask

   // Typical use: clear, load a few records, usually sort, then look up and list
   task automatic run_sequence();
      int n;
      bit narrow;
      if ($urandom_range(0, 9) != 0 || fill_level > 60) plain(CMD_CLEAR);
      narrow = ($urandom_range(0, 1) == 1);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      repeat (n) append_rec(rand_key(narrow), YEAR_W'($urandom),
                            MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom));
      if ($urandom_range(0, 4) != 0) plain(CMD_SORT);
      repeat ($urandom_range(1, 8)) begin
         if (held_keys.size() > 0 && $urandom_range(0, 99) < 70)
            search_for(held_keys[$urandom_range(0, held_keys.size() - 1)]);
         else
            search_for(rand_key(narrow));
      end
      repeat ($urandom_range(1, 5)) begin
         if (fill_level > 0 && $urandom_range(0, 3) != 0)
            read_at(IDX_W'($urandom_range(0, fill_level - 1)));
         else
            read_at(IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
      end
   endtask

   // Fill to capacity, overflow it, then sort and look up at full size
   task automatic fill_whole_table();
      plain(CMD_CLEAR);
      repeat (DEPTH + 2) append_rec(KEY_W'($urandom), YEAR_W'($urandom),
                                    MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom));
      repeat (4) search_for(held_keys[$urandom_range(0, held_keys.size() - 1)]);
      plain(CMD_SORT);
      repeat (10) search_for(held_keys[$urandom_range(0, held_keys.size() - 1)]);
      search_for(KEY_W'($urandom));
      read_at('0);
      read_at(IDX_W'(DEPTH - 1));
      repeat (4) read_at(IDX_W'($urandom_range(0, DEPTH - 1)));
      plain(CMD_SORT);
      plain(CMD_CLEAR);
   endtask

   // Result side: random ready pattern, plus one long hold-off on request
   initial begin
      int  span;
      bit  level;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (results_held_off) begin
            level = 1'b0;
            span  = HOLD_CYCLES;
            results_held_off = 1'b0;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin level = 1'b1; span = $urandom_range(1, 30); end
               9:          begin level = 1'b0; span = $urandom_range(10, 40); end
               default:    begin level = 1'b0; span = $urandom_range(1, 3); end
            endcase
         end
         rsp_ready <= level;
         repeat (span - 1) @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      bit big_done, pressure_done;
      big_done      = 1'b0;
      pressure_done = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table corners
      search_for(30'd5);
      read_at(9'd0);
      plain(CMD_SORT);
      // Field extremes and a duplicated key, left unsorted
      append_rec('1, '1, '1, '1);
      append_rec('0, '0, '0, '0);
      append_rec(30'd999_999_999, 14'd9999, 4'd12, 5'd31);
      append_rec(30'd500, 14'd2015, 4'd3, 5'd7);
      append_rec(30'd500, 14'd2016, 4'd4, 5'd8);
      search_for(30'd500);
      read_at(9'd0);
      read_at(9'd4);
      read_at(9'd5);
      read_at('1);
      // Sorted look-ups, hits, a duplicate and a miss
      plain(CMD_SORT);
      search_for(30'd0);
      search_for(30'd500);
      search_for('1);
      search_for(30'd1);
      for (int i = 1; i < 4; i++) read_at(i[IDX_W-1:0]);
      // Spare command codes change nothing
      for (int c = CMD_READ + 1; c < (1 << CMD_W); c++) plain(CMD_W'(c));
      plain(CMD_CLEAR);
      read_at(9'd0);

      // Random part
      while (items_sent < ITEM_TARGET) begin
         if (!pressure_done && items_sent >= 150) begin
            results_held_off = 1'b1;
            pressure_done    = 1'b1;
         end
         if (!big_done && items_sent >= 600) begin
            big_done = 1'b1;
            fill_whole_table();
         end
         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 85) begin
            run_sequence();
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(CMD_W'($urandom), KEY_W'($urandom), YEAR_W'($urandom),
                         MONTH_W'($urandom), DAY_W'($urandom), IDX_W'($urandom));
         end
      end
      req_valid <= 1'b0;

      wait (pending_results == 0);
      repeat (20) @(posedge clock);
      if (fault_count == 0 && pending_results == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
sv/skts_pkg.sv
sv/skts_ram.sv
sv/skts_ctrl.sv
sv/skts_dpath.sv
sv/sorted_key_table_search_unit.sv
sv/skts_chk.sv
tb/sv/skts_result_checker.sv
tb/sv/tb_sorted_key_table_search_unit.sv
